// ----- sv/lfu_pkg.sv -----
// Package for the LFU cache table: sizes, codes, controller types.
// No dependencies; used by every module of the block.
package lfu_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int DATA_W          = 32;
   localparam int CAP_W           = 7;
   localparam int ADDR_W          = 3;

   localparam logic [CAP_W-1:0]  CAP_RESET    = 7'd64;
   localparam logic [DATA_W-1:0] NO_VALUE     = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;
   localparam logic [ADDR_W-1:0] REG_CAPACITY = 3'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_TOUCH,
      MODE_INSERT
   } mode_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic phase_upd;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic issue_done;
      logic pass_done;
   } status_type;

endpackage

// ----- sv/lfu_cache_table.sv -----
// Top level of the LFU cache table: configuration register and block wiring.
// Depends on lfu_pkg, lfu_ctrl and lfu_dpath.
//
//   channel   ports                               handshake
//   request   req_kind, req_key, req_value        start high and busy low
//   result    rsp_hit, rsp_read_value, rsp_evicted  rsp_valid, one cycle, no stall
//   config    psel penable pwrite paddr pwdata    psel & penable & pwrite
//
// During a transaction busy stays high from acceptance until the result: the
// single-port entry table is walked once to find the key, the free slot and the
// victim, and once more to rewrite ranks and the touched entry. Each walk reads
// every entry and then drains the read pipeline; one decide state sits between
// the walks and one result state follows them.
// The result strobe rsp_valid rises in the last busy cycle and lasts one cycle.
// Synchronous reset clears all valid bits at once and sets capacity to 64.
// The receiver cannot stall; results are never held.
module lfu_cache_table
   import lfu_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_kind,
   input  logic [DATA_W-1:0] req_key,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_valid,
   output logic              rsp_hit,
   output logic [DATA_W-1:0] rsp_read_value,
   output logic              rsp_evicted,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   cmd_type          cmd;
   status_type       status;

   assign pready = 1'b1;

   // capture capacity on the access phase of a write to its address
   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && paddr == REG_CAPACITY) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata = (paddr == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity_ff} : 32'd0;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   lfu_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .capacity       (capacity_ff),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .rsp_evicted    (rsp_evicted)
   );

endmodule

// ----- sv/lfu_ctrl.sv -----
// Controller state machine for the LFU cache table.
// Depends on lfu_pkg; drives lfu_dpath through cmd_type, reads status_type.
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = !status.issue_done;
            if (status.pass_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.phase_upd = 1'b1;
            cmd.issue     = !status.issue_done;
            if (status.pass_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("result strobe not followed by idle");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy) else $error("load while busy");
   a_issue_phase: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (state_ff == ST_SCAN || state_ff == ST_UPDATE))
      else $error("read issued outside a table walk");

endmodule

// ----- sv/lfu_dpath.sv -----
// Datapath of the LFU cache table: entry memory, valid bits, scan and update logic.
// Depends on lfu_pkg; commanded by lfu_ctrl.
module lfu_dpath
   import lfu_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
)(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [CAP_W-1:0]  capacity,
   input  logic              req_kind,
   input  logic [DATA_W-1:0] req_key,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_hit,
   output logic [DATA_W-1:0] rsp_read_value,
   output logic              rsp_evicted
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int WORD_W = 3 * DATA_W + IDX_W;

   // entry word: {key, value, use count, recency rank}
   logic [WORD_W-1:0] mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic              kind_ff;
   logic [DATA_W-1:0] key_ff, val_ff;
   logic [CNT_W-1:0]  addr_ff;
   logic              pv_ff;
   logic [IDX_W-1:0]  pidx_ff;
   logic [WORD_W-1:0] rd_ff;
   logic              rvalid_ff;

   // scan results
   logic              found_ff, free_found_ff, vic_found_ff;
   logic [IDX_W-1:0]  s_idx_ff, free_idx_ff, vic_idx_ff;
   logic [DATA_W-1:0] s_val_ff, vic_cnt_ff;
   logic [IDX_W-1:0]  s_rank_ff, vic_rank_ff;
   logic [CNT_W-1:0]  used_ff;

   // decision
   mode_type          mode_ff, mode_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [IDX_W-1:0]  rv_ff, rv_in;
   logic              evict_ff, evict_in;
   logic              hit_ff;
   logic [DATA_W-1:0] rval_ff, rval_in;

   logic [DATA_W-1:0] rd_key, rd_val, rd_cnt;
   logic [IDX_W-1:0]  rd_rank;
   logic              full;
   logic              we;
   logic [WORD_W-1:0] wdata;
   logic              set_valid;

   assign rd_key  = rd_ff[WORD_W-1 -: DATA_W];
   assign rd_val  = rd_ff[WORD_W-DATA_W-1 -: DATA_W];
   assign rd_cnt  = rd_ff[IDX_W+DATA_W-1 -: DATA_W];
   assign rd_rank = rd_ff[IDX_W-1:0];

   assign status.issue_done = (addr_ff == CNT_W'(ENTRIES));
   assign status.pass_done  = status.issue_done && !pv_ff;

   // read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         pv_ff   <= 1'b0;
      end else begin
         pv_ff <= cmd.issue;
         if (cmd.load || cmd.decide) begin
            addr_ff <= '0;
         end else if (cmd.issue) begin
            addr_ff <= addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_ff     <= mem[addr_ff[IDX_W-1:0]];
         rvalid_ff <= valid_ff[addr_ff[IDX_W-1:0]];
         pidx_ff   <= addr_ff[IDX_W-1:0];
      end
      if (we) mem[pidx_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
         val_ff  <= req_value;
      end
   end

   // scan accumulation
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff  <= 1'b0;
         used_ff       <= '0;
      end else if (pv_ff && !cmd.phase_upd) begin
         if (rvalid_ff) begin
            used_ff <= used_ff + 1'b1;
            if (rd_key == key_ff && !found_ff) begin
               found_ff  <= 1'b1;
               s_idx_ff  <= pidx_ff;
               s_val_ff  <= rd_val;
               s_rank_ff <= rd_rank;
            end
            if (!vic_found_ff || rd_cnt < vic_cnt_ff ||
                (rd_cnt == vic_cnt_ff && rd_rank > vic_rank_ff)) begin
               vic_found_ff <= 1'b1;
               vic_idx_ff   <= pidx_ff;
               vic_cnt_ff   <= rd_cnt;
               vic_rank_ff  <= rd_rank;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= pidx_ff;
         end
      end
   end

   assign full = (32'(used_ff) >= 32'(capacity)) || (used_ff == CNT_W'(ENTRIES));

   always_comb begin
      mode_in  = MODE_NONE;
      slot_in  = s_idx_ff;
      rv_in    = vic_rank_ff;
      evict_in = 1'b0;
      rval_in  = NO_VALUE;
      if (!kind_ff) begin
         if (found_ff) begin
            mode_in = MODE_TOUCH;
            rval_in = s_val_ff;
         end
      end else if (capacity != '0) begin
         if (found_ff) begin
            mode_in = MODE_TOUCH;
         end else begin
            mode_in = MODE_INSERT;
            if (full) begin
               evict_in = 1'b1;
               slot_in  = vic_idx_ff;
            end else begin
               slot_in = free_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else if (cmd.decide) begin
         mode_ff  <= mode_in;
         slot_ff  <= slot_in;
         rv_ff    <= rv_in;
         evict_ff <= evict_in;
         hit_ff   <= found_ff;
         rval_ff  <= rval_in;
      end
   end

   // rank and entry rewrite during the update walk
   always_comb begin
      we        = 1'b0;
      set_valid = 1'b0;
      wdata     = {rd_key, rd_val, rd_cnt, rd_rank + 1'b1};
      if (pv_ff && cmd.phase_upd) begin
         case (mode_ff)
            MODE_TOUCH: begin
               if (pidx_ff == slot_ff) begin
                  we    = 1'b1;
                  wdata = {rd_key, kind_ff ? val_ff : rd_val,
                           (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1, {IDX_W{1'b0}}};
               end else if (rvalid_ff && rd_rank < s_rank_ff) begin
                  we = 1'b1;
               end
            end
            MODE_INSERT: begin
               if (pidx_ff == slot_ff) begin
                  we        = 1'b1;
                  set_valid = 1'b1;
                  wdata     = {key_ff, val_ff, DATA_W'(1), {IDX_W{1'b0}}};
               end else if (rvalid_ff && !(evict_ff && rd_rank > rv_ff)) begin
                  we = 1'b1;
               end
            end
            default: we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (set_valid) begin
         valid_ff[pidx_ff] <= 1'b1;
      end
   end

   assign rsp_hit        = hit_ff;
   assign rsp_read_value = rval_ff;
   assign rsp_evicted    = evict_ff && (mode_ff == MODE_INSERT);

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      we |-> cmd.phase_upd && pv_ff) else $error("table write outside update walk");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(ENTRIES)) else $error("occupancy count overflow");
   a_pipe_follows_issue: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> $past(cmd.issue)) else $error("read data without a read");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the LFU cache table: gets and puts with a running
// table model, capacity changes over the APB-style port. Depends on lfu_pkg and
// lfu_cache_table.
module tb;
   import lfu_pkg::*;

   localparam int NUM_SLOTS   = ENTRIES_DEFAULT;
   localparam int BLOCK_LAT   = 2 * NUM_SLOTS + 6;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
   } lookup_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_kind;
   logic [DATA_W-1:0] req_key;
   logic [DATA_W-1:0] req_value;
   logic              rsp_valid;
   logic              rsp_hit;
   logic [DATA_W-1:0] rsp_read_value;
   logic              rsp_evicted;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   lfu_cache_table DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_read_value(rsp_read_value),
      .rsp_evicted(rsp_evicted),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // Shadow copy of the cache table and its capacity register.
   logic [CAP_W-1:0]  cap_reg;
   logic              slot_valid [NUM_SLOTS];
   logic [DATA_W-1:0] slot_key   [NUM_SLOTS];
   logic [DATA_W-1:0] slot_value [NUM_SLOTS];
   logic [DATA_W-1:0] slot_count [NUM_SLOTS];
   int                slot_age   [NUM_SLOTS];

   lookup_result_type pending_results[$];
   logic [DATA_W-1:0] key_pool[16];
   int  error_count = 0;
   int  cycle_count = 0;
   int  sent_count  = 0;
   int  hit_seen    = 0;
   int  evict_seen  = 0;
   bit  idle_enable = 1'b1;

   // Bump a hit entry: newer entries age by one, count saturates.
   function automatic void promote_slot(int s);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (i != s && slot_valid[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
      slot_age[s] = 0;
      if (slot_count[s] != COUNT_MAX) slot_count[s]++;
   endfunction

   // Apply one request to the shadow table and return what the block must answer.
   function automatic lookup_result_type apply_request(logic kind, logic [DATA_W-1:0] key,
                                                        logic [DATA_W-1:0] value);
      lookup_result_type r;
      int cap, found, used, slot, victim;
      cap   = (cap_reg > NUM_SLOTS) ? NUM_SLOTS : int'(cap_reg);
      found = -1;
      used  = 0;
      slot  = -1;
      victim = -1;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      r.hit = (found >= 0);
      r.read_value = NO_VALUE;
      r.evicted = 1'b0;
      if (kind == OP_GET) begin
         if (found >= 0) begin
            r.read_value = slot_value[found];
            promote_slot(found);
         end
         return r;
      end
      if (cap == 0) return r;
      if (found >= 0) begin
         slot_value[found] = value;
         promote_slot(found);
         return r;
      end
      for (int i = 0; i < NUM_SLOTS; i++) if (slot_valid[i]) used++;
      if (used >= cap) begin
         // lowest count wins, oldest breaks ties
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_valid[i]) continue;
            if (victim < 0 || slot_count[i] < slot_count[victim] ||
                (slot_count[i] == slot_count[victim] && slot_age[i] > slot_age[victim]))
               victim = i;
         end
         if (victim >= 0) begin
            slot_valid[victim] = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot_valid[i] && slot_age[i] > slot_age[victim]) slot_age[i]--;
            r.evicted = 1'b1;
            slot = victim;
         end
      end
      if (slot < 0)
         for (int i = 0; i < NUM_SLOTS; i++)
            if (slot < 0 && !slot_valid[i]) slot = i;
      if (slot < 0) return r;
      for (int i = 0; i < NUM_SLOTS; i++) if (slot_valid[i]) slot_age[i]++;
      slot_valid[slot] = 1'b1;
      slot_key[slot]   = key;
      slot_value[slot] = value;
      slot_count[slot] = DATA_W'(1);
      slot_age[slot]   = 0;
      return r;
   endfunction

   // Send one request; hold start until the block takes it, then drop it.
   task automatic send_request(logic kind, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
      if (idle_enable && $urandom_range(99) < 33)
         repeat ($urandom_range(1, BLOCK_LAT + 10)) @(negedge clock);
      @(negedge clock);
      start     <= 1'b1;
      req_kind  <= kind;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_request(kind, key, value));
      sent_count++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   // Drain all results, then let the block settle before touching the register.
   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (BLOCK_LAT + 4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [31:0] value);
      wait_drained();
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= REG_CAPACITY;
      pwdata  <= value;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cap_reg = value[CAP_W-1:0];
   endtask

   function automatic logic [DATA_W-1:0] pick_key();
      if ($urandom_range(9) == 0) return $urandom();
      return key_pool[$urandom_range(15)];
   endfunction

   // Check each result strobe against the oldest expectation.
   always @(posedge clock) begin
      lookup_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result hit=%0b value=%h evicted=%0b", $time,
                     rsp_hit, rsp_read_value, rsp_evicted);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit) hit_seen++;
            if (rsp_evicted) evict_seen++;
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_hit);
               error_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time,
                        want.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_evicted !== want.evicted) begin
               $display("%0t: evicted expected %0b actual %0b", $time,
                        want.evicted, rsp_evicted);
               error_count++;
            end
         end
      end
   end

   // Fill two slots, then force LRU tie-break and LFU choice.
   task automatic test_eviction_order();
      write_capacity(2);
      send_request(OP_PUT, 32'h0000_0001, 32'h1111_1111);
      send_request(OP_PUT, 32'h0000_0002, 32'h2222_2222);
      send_request(OP_PUT, 32'h0000_0003, 32'h3333_3333);   // tie: oldest goes
      send_request(OP_GET, 32'h0000_0001, 32'h0);
      send_request(OP_GET, 32'h0000_0003, 32'h0);
      send_request(OP_GET, 32'h0000_0003, 32'h0);
      send_request(OP_PUT, 32'h0000_0002, 32'h4444_4444);   // put hit on key 2
      send_request(OP_PUT, 32'h0000_0004, 32'h5555_5555);   // lowest count goes
      send_request(OP_PUT, 32'h0000_0003, 32'h6666_6666);   // put hit overwrites
      send_request(OP_GET, 32'h0000_0003, 32'hFFFF_FFFF);
   endtask

   // Extreme keys and values at full capacity.
   task automatic test_field_extremes();
      write_capacity(127);   // saturates to the table size
      send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'h0);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h1234_5678, 32'h0);
   endtask

   // Zero capacity stores nothing but still reports hits; then shrink below occupancy.
   task automatic test_capacity_edges();
      write_capacity(0);
      send_request(OP_PUT, 32'h8000_0000, 32'hDEAD_BEEF);
      send_request(OP_PUT, 32'h0BAD_F00D, 32'h1);
      send_request(OP_GET, 32'h8000_0000, 32'h0);
      send_request(OP_GET, 32'h0BAD_F00D, 32'h0);
      write_capacity(1);
      send_request(OP_PUT, 32'h0BAD_F00D, 32'h2);
      send_request(OP_PUT, 32'h0000_00AA, 32'h3);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
   endtask

   // Mostly pooled keys so hits and evictions are frequent, with noise keys mixed in.
   task automatic test_random_traffic(int num_items);
      for (int n = 0; n < num_items; n++) begin
         if (n % 90 == 89) begin
            case ($urandom_range(3))
               0: write_capacity(64);
               1: write_capacity($urandom_range(1, 8));
               2: write_capacity($urandom_range(0, 127));
               default: write_capacity(3);
            endcase
         end
         idle_enable = !(n >= 150 && n < 230);   // back-to-back stretch
         if (n == 300) wait_drained();           // hold off until all results are in
         send_request($urandom_range(1), pick_key(), $urandom());
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      reset = 1'b1; start = 1'b0; req_kind = 1'b0; req_key = '0; req_value = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      cap_reg = CAP_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_valid[i] = 1'b0; slot_key[i] = '0; slot_value[i] = '0;
         slot_count[i] = '0; slot_age[i] = 0;
      end
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_eviction_order();
      test_field_extremes();
      test_capacity_edges();
      test_random_traffic(470);

      wait_drained();
      $display("Covered %0d requests, %0d hits, %0d evictions, capacities 0 to 127.",
               sent_count, hit_seen, evict_seen);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
